// ===== hdl/spfr_pkg.sv =====
// ============================================================================
// spfr_pkg - shared definitions for the status poll frame responder
// Frame codes, status codes, reply descriptor and queue status types.
// ============================================================================
package spfr_pkg;

    localparam logic [7:0] HDR_POLL     = 8'hAA;
    localparam logic [7:0] HDR_ANNOUNCE = 8'h55;
    localparam logic [7:0] ST_NORMAL    = 8'h01;
    localparam logic [7:0] ST_ALARM     = 8'h02;
    localparam logic [7:0] ST_FAULT     = 8'h03;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       fled;
        logic       aled;
    } reply_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== hdl/spfr_front.sv =====
// ============================================================================
// spfr_front - frame parser
// Accepts input transfers, tracks frame position and announce request, and
// pushes one reply descriptor per completed frame that needs a reply.
// ============================================================================
module spfr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [7:0]        rx_byte,
    input  logic              fault_active,
    input  logic              alarm_active,
    input  logic [7:0]        bus_address,
    input  spfr_pkg::qstat_t  q_stat,
    output logic              push,
    output spfr_pkg::reply_t  push_data
);
    import spfr_pkg::*;

    localparam logic [1:0] POS_HEADER  = 2'd0;
    localparam logic [1:0] POS_ADDRESS = 2'd1;
    localparam logic [1:0] POS_DATA    = 2'd2;
    localparam logic [1:0] POS_CHECK   = 2'd3;

    logic [1:0] pos_reg, pos_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] data_reg, data_next;
    logic       announce_reg, announce_next;
    logic       accept;
    logic [7:0] check_sum;
    logic [7:0] status;

    assign in_ready  = !q_stat.full;
    assign accept    = in_valid && in_ready;
    assign check_sum = HDR_POLL + addr_reg + data_reg;

    always_comb
    begin
        priority if (alarm_active)
            status = ST_ALARM;
        else if (fault_active)
            status = ST_FAULT;
        else
            status = ST_NORMAL;
    end

    always_comb
    begin
        pos_next      = pos_reg;
        addr_next     = addr_reg;
        data_next     = data_reg;
        announce_next = announce_reg;
        push          = 1'b0;
        push_data     = '{b0: HDR_ANNOUNCE, b1: addr_reg, b2: bus_address,
                          fled: 1'b0, aled: 1'b0};
        if (accept)
        begin
            if (operation)
            begin
                announce_next = 1'b1;
            end
            else
            begin
                unique case (pos_reg)
                    POS_HEADER:
                    begin
                        if (rx_byte == HDR_POLL)
                            pos_next = POS_ADDRESS;
                    end
                    POS_ADDRESS:
                    begin
                        addr_next = rx_byte;
                        pos_next  = POS_DATA;
                    end
                    POS_DATA:
                    begin
                        data_next = rx_byte;
                        pos_next  = POS_CHECK;
                    end
                    POS_CHECK:
                    begin
                        pos_next = POS_HEADER;
                        if (announce_reg || addr_reg != bus_address)
                        begin
                            announce_next = 1'b0;
                            push          = 1'b1;
                        end
                        else if (rx_byte == check_sum)
                        begin
                            push      = 1'b1;
                            push_data = '{b0: HDR_POLL, b1: addr_reg, b2: status,
                                          fled: fault_active, aled: alarm_active};
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_HEADER;
            addr_reg     <= '0;
            data_reg     <= '0;
            announce_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            addr_reg     <= addr_next;
            data_reg     <= data_next;
            announce_reg <= announce_next;
        end
    end

endmodule

// ===== hdl/spfr_queue.sv =====
// ============================================================================
// spfr_queue - reply descriptor queue
// Short FIFO between parser and serializer so each side stalls on its own.
// ============================================================================
module spfr_queue #(
    parameter int DEPTH = spfr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  spfr_pkg::reply_t  push_data,
    input  logic              pop,
    output spfr_pkg::reply_t  head,
    output spfr_pkg::qstat_t  q_stat
);
    import spfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    reply_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/spfr_back.sv =====
// ============================================================================
// spfr_back - reply serializer
// Loads a reply descriptor and sends its four bytes, one per output transfer.
// ============================================================================
module spfr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  spfr_pkg::reply_t  head,
    input  spfr_pkg::qstat_t  q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        tx_byte,
    output logic              last,
    output logic              fault_led_on,
    output logic              alarm_led_on
);
    import spfr_pkg::*;

    localparam logic [1:0] IDX_B0  = 2'd0;
    localparam logic [1:0] IDX_B1  = 2'd1;
    localparam logic [1:0] IDX_B2  = 2'd2;
    localparam logic [1:0] IDX_SUM = 2'd3;

    reply_t     rep_reg;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       done;
    logic [7:0] sum;

    assign out_valid    = busy_reg;
    assign last         = (idx_reg == IDX_SUM);
    assign fault_led_on = rep_reg.fled;
    assign alarm_led_on = rep_reg.aled;
    assign sum          = rep_reg.b0 + rep_reg.b1 + rep_reg.b2;
    assign done         = busy_reg && out_ready && last;
    assign pop          = (!busy_reg || done) && !q_stat.empty;

    always_comb
    begin
        unique case (idx_reg)
            IDX_B0:  tx_byte = rep_reg.b0;
            IDX_B1:  tx_byte = rep_reg.b1;
            IDX_B2:  tx_byte = rep_reg.b2;
            IDX_SUM: tx_byte = sum;
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            idx_next  = IDX_B0;
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && out_ready)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rep_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= IDX_B0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== hdl/status_poll_frame_responder.sv =====
// ============================================================================
// status_poll_frame_responder - poll frame parser and reply sender
// Parses four-byte poll frames and sends a four-byte status or announce reply.
// ============================================================================
// The checksum byte transfer queues a descriptor; the first reply byte follows once the serializer loads it.
// Throughput: one input transfer per cycle while the queue has space; replies go out
//   one byte per cycle while out_ready is high, four byte transfers per reply.
// The input side stalls only while the descriptor queue (QUEUE_DEPTH) is full.
// Reset: asynchronous, clears parse state, announce flag, bus address, queue.
module status_poll_frame_responder #(
    parameter int QUEUE_DEPTH = spfr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] rx_byte,
    input  logic       fault_active,
    input  logic       alarm_active,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       last,
    output logic       fault_led_on,
    output logic       alarm_led_on
);
    import spfr_pkg::*;

    logic [7:0] bus_address_reg;
    logic       push;
    logic       pop;
    reply_t     push_data;
    reply_t     head;
    qstat_t     q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bus_address_reg <= '0;
        else if (cfg_we)
            bus_address_reg <= cfg_wdata;
    end

    spfr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .fault_active (fault_active),
        .alarm_active (alarm_active),
        .bus_address  (bus_address_reg),
        .q_stat       (q_stat),
        .push         (push),
        .push_data    (push_data)
    );

    spfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    spfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tx_byte      (tx_byte),
        .last         (last),
        .fault_led_on (fault_led_on),
        .alarm_led_on (alarm_led_on)
    );

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("reply pushed into full queue");

    a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_stat.full)
        else $error("input stalled with queue space left");

    a_reply_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_stat.empty))
        else $error("reply started without a queued descriptor");

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !(out_ready && last)) |-> !pop)
        else $error("descriptor popped while reply in progress");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status poll frame responder testbench
// Drives poll frames, announce requests and stray bytes through the
// valid/ready input, rebuilds the expected reply bytes from a local frame
// parser, and compares each reply byte transfer in order.
// ----------------------------------------------------------------------------
module testbench;
    import spfr_pkg::*;

    localparam int  HOLDOFF_CYCLES = 120;
    localparam int  STALL_LIMIT    = 2000;
    localparam int  DRAIN_CYCLES   = 12;
    localparam int  RANDOM_ITEMS   = 192;
    localparam int  IDLE_PCT       = 32;
    localparam int  REPORT_LIMIT   = 10;
    localparam bit  OP_RX_BYTE     = 1'b0;
    localparam bit  OP_ANNOUNCE    = 1'b1;

    typedef enum logic [1:0] {
        PARSE_WAIT_HDR = 2'd0,
        PARSE_ADDR     = 2'd1,
        PARSE_DATA     = 2'd2,
        PARSE_SUM      = 2'd3
    } parse_pos_t;

    typedef struct {
        logic [7:0] tx;
        logic       fin;
        logic       fled;
        logic       aled;
    } reply_byte_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_we       = 1'b0;
    logic [7:0] cfg_wdata    = 8'h00;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic       operation    = 1'b0;
    logic [7:0] rx_byte      = 8'h00;
    logic       fault_active = 1'b0;
    logic       alarm_active = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] tx_byte;
    logic       last;
    logic       fault_led_on;
    logic       alarm_led_on;

    parse_pos_t  parse_pos_q        = PARSE_WAIT_HDR;
    logic [7:0]  frame_addr_q       = 8'h00;
    logic [7:0]  frame_data_q       = 8'h00;
    logic        announce_pending_q = 1'b0;
    logic [7:0]  bus_addr_q         = 8'h00;
    reply_byte_t reply_bytes_due[$];

    int in_idle_pct       = IDLE_PCT;
    int out_idle_pct      = IDLE_PCT;
    int holdoff_request   = 0;
    int mismatch_count    = 0;
    int items_sent        = 0;
    int useful_items      = 0;
    int bytes_checked     = 0;
    int status_replies    = 0;
    int announce_replies  = 0;
    int checksum_drops    = 0;
    int announce_requests = 0;
    int config_writes     = 0;

    status_poll_frame_responder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .fault_active (fault_active),
        .alarm_active (alarm_active),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tx_byte      (tx_byte),
        .last         (last),
        .fault_led_on (fault_led_on),
        .alarm_led_on (alarm_led_on)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] poll_sum(logic [7:0] addr, logic [7:0] data);
        return HDR_POLL + addr + data;
    endfunction

    function automatic void queue_reply(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                        logic fled, logic aled);
        logic [7:0] sum;
        sum = b0 + b1 + b2;
        reply_bytes_due.push_back('{b0, 1'b0, fled, aled});
        reply_bytes_due.push_back('{b1, 1'b0, fled, aled});
        reply_bytes_due.push_back('{b2, 1'b0, fled, aled});
        reply_bytes_due.push_back('{sum, 1'b1, fled, aled});
    endfunction

    // Return 1 unless the byte is dropped while hunting for a header.
    function automatic bit parse_poll_byte(bit op, logic [7:0] rx, bit fault, bit alarm);
        logic [7:0] status_code;
        if (op == OP_ANNOUNCE)
        begin
            announce_pending_q = 1'b1;
            announce_requests++;
            return 1'b1;
        end
        case (parse_pos_q)
            PARSE_WAIT_HDR:
            begin
                if (rx != HDR_POLL)
                    return 1'b0;
                parse_pos_q = PARSE_ADDR;
                return 1'b1;
            end
            PARSE_ADDR:
            begin
                frame_addr_q = rx;
                parse_pos_q  = PARSE_DATA;
                return 1'b1;
            end
            PARSE_DATA:
            begin
                frame_data_q = rx;
                parse_pos_q  = PARSE_SUM;
                return 1'b1;
            end
            default: ;
        endcase
        parse_pos_q = PARSE_WAIT_HDR;
        if (announce_pending_q || frame_addr_q != bus_addr_q)
        begin
            announce_pending_q = 1'b0;
            queue_reply(HDR_ANNOUNCE, frame_addr_q, bus_addr_q, 1'b0, 1'b0);
            announce_replies++;
        end
        else if (rx != poll_sum(frame_addr_q, frame_data_q))
        begin
            checksum_drops++;
        end
        else
        begin
            status_code = ST_NORMAL;
            if (fault)
                status_code = ST_FAULT;
            if (alarm)
                status_code = ST_ALARM;
            queue_reply(HDR_POLL, frame_addr_q, status_code, fault, alarm);
            status_replies++;
        end
        return 1'b1;
    endfunction

    task automatic send_item(bit op, logic [7:0] rx, bit fault, bit alarm);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        rx_byte      <= rx;
        fault_active <= fault;
        alarm_active <= alarm;
        do
            @(posedge clk);
        while (!in_ready);
        if (parse_poll_byte(op, rx, fault, alarm))
            useful_items++;
        items_sent++;
    endtask

    // Fault and alarm are random on the first three bytes; only the last one counts.
    task automatic send_poll_frame(logic [7:0] addr, logic [7:0] data, logic [7:0] sum,
                                   bit fault, bit alarm);
        send_item(OP_RX_BYTE, HDR_POLL, 1'($urandom_range(1)), 1'($urandom_range(1)));
        send_item(OP_RX_BYTE, addr, 1'($urandom_range(1)), 1'($urandom_range(1)));
        send_item(OP_RX_BYTE, data, 1'($urandom_range(1)), 1'($urandom_range(1)));
        send_item(OP_RX_BYTE, sum, fault, alarm);
    endtask

    task automatic wait_replies_done();
        in_valid <= 1'b0;
        while (reply_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bus_address(logic [7:0] value);
        wait_replies_done();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        bus_addr_q = value;
        config_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_stray_bytes();
        send_item(OP_RX_BYTE, 8'h00, 1'b1, 1'b1);
        send_item(OP_RX_BYTE, 8'hFF, 1'b0, 1'b1);
        send_item(OP_RX_BYTE, HDR_ANNOUNCE, 1'b1, 1'b0);
    endtask

    task automatic test_status_replies();
        send_poll_frame(8'h00, 8'hFF, poll_sum(8'h00, 8'hFF), 1'b1, 1'b1);
        write_bus_address(8'hFF);
        send_poll_frame(8'hFF, HDR_POLL, poll_sum(8'hFF, HDR_POLL), 1'b1, 1'b0);
    endtask

    task automatic test_announce();
        send_item(OP_RX_BYTE, HDR_POLL, 1'b0, 1'b0);
        send_item(OP_RX_BYTE, bus_addr_q, 1'b0, 1'b0);
        send_item(OP_ANNOUNCE, HDR_POLL, 1'b1, 1'b1);
        send_item(OP_RX_BYTE, 8'h5A, 1'b0, 1'b0);
        send_item(OP_RX_BYTE, poll_sum(bus_addr_q, 8'h5A), 1'b1, 1'b1);
        send_poll_frame(8'h12, 8'h34, 8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_checksum_error();
        send_poll_frame(bus_addr_q, 8'h80, poll_sum(bus_addr_q, 8'h80) ^ 8'h01, 1'b0, 1'b1);
    endtask

    task automatic run_random_items(int count);
        int         goal;
        int         pick;
        logic [7:0] addr;
        logic [7:0] data;
        logic [7:0] sum;
        goal = useful_items + count;
        while (useful_items < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_item(OP_ANNOUNCE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
            else if (pick < 18)
            begin
                send_item(OP_RX_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
            else
            begin
                addr = ($urandom_range(99) < 70) ? bus_addr_q : 8'($urandom_range(255));
                data = 8'($urandom_range(255));
                sum  = poll_sum(addr, data);
                if ($urandom_range(99) < 20)
                    sum = sum + 8'($urandom_range(255, 1));
                send_poll_frame(addr, data, sum, 1'($urandom_range(1)),
                                1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_random_traffic();
        write_bus_address(8'($urandom_range(255)));
        run_random_items(RANDOM_ITEMS / 4);
        write_bus_address(8'h00);
        run_random_items(RANDOM_ITEMS / 4);
        write_bus_address(8'hFF);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random_items(RANDOM_ITEMS / 4);
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
        write_bus_address(8'($urandom_range(254, 1)));
        run_random_items(RANDOM_ITEMS / 4);
    endtask

    task automatic test_output_backpressure();
        logic [7:0] data;
        wait_replies_done();
        in_idle_pct = 0;
        holdoff_request++;
        repeat (8)
        begin
            data = 8'($urandom_range(255));
            send_poll_frame(bus_addr_q, data, poll_sum(bus_addr_q, data),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        in_idle_pct = IDLE_PCT;
        wait_replies_done();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stray_bytes();
        test_status_replies();
        test_announce();
        test_checksum_error();
        test_random_traffic();
        test_output_backpressure();
        wait_replies_done();
        $display("covered %0d items (%0d parsed), %0d announce requests, %0d address writes",
                 items_sent, useful_items, announce_requests, config_writes);
        $display("replies: %0d status, %0d announce, %0d checksum drops, %0d bytes checked",
                 status_replies, announce_replies, checksum_drops, bytes_checked);
        if (mismatch_count == 0 && reply_bytes_due.size() == 0)
            $display("status_poll_frame_responder regression: pass");
        else
            $display("status_poll_frame_responder regression: fail");
        $finish;
    end

    // Hold ready low for a long stretch on request, otherwise stall at random.
    initial
    begin
        int holdoff_seen;
        int hold_left;
        holdoff_seen = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_seen != holdoff_request)
            begin
                holdoff_seen = holdoff_request;
                hold_left    = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        reply_byte_t due;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_checked++;
            if (reply_bytes_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected reply byte: tx %02h last %0b fault %0b alarm %0b",
                             tx_byte, last, fault_led_on, alarm_led_on);
            end
            else
            begin
                due = reply_bytes_due.pop_front();
                if (tx_byte !== due.tx || last !== due.fin ||
                    fault_led_on !== due.fled || alarm_led_on !== due.aled)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"reply mismatch: expected tx %02h last %0b fault %0b ",
                                  "alarm %0b, got tx %02h last %0b fault %0b alarm %0b"},
                                 due.tx, due.fin, due.fled, due.aled,
                                 tx_byte, last, fault_led_on, alarm_led_on);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int stall_cycles;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d reply bytes outstanding",
                     stall_cycles, reply_bytes_due.size());
            $display("status_poll_frame_responder regression: fail");
            $finish;
        end
    end

endmodule
